[design/bldc_pi_speed_commutation_core_defines.svh]
// ============================================================================
// Assertion macros for the BLDC PI speed and commutation core
// Concurrent checks on clk with asynchronous active-low reset rst_n.
// In synthesis the macros expand to nothing.
// ============================================================================
`ifndef BLDC_PI_SPEED_COMMUTATION_CORE_DEFINES_SVH
`define BLDC_PI_SPEED_COMMUTATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BPSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define BPSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/bpsc_pkg.sv]
// ============================================================================
// bpsc_pkg
// Types, constants and hall tables shared by the speed and commutation core.
// ============================================================================
`timescale 1ns / 1ps

package bpsc_pkg;

    localparam int GAIN_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int WINDUP_W   = 31;
    localparam int OFFSET_W   = 23;
    localparam int INTEG_W    = 32;
    localparam int FSPEED_W   = 32;
    localparam int DUTY_W     = 7;
    localparam int HALL_W     = 3;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 24'd65536;

    localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_WINDUP_LIMIT = 3'd2,
        REG_LOOP_ENABLE  = 3'd3,
        REG_DUTY_GAIN    = 3'd4,
        REG_DUTY_OFFSET  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DS_STOP = 2'd0,
        DS_CW   = 2'd1,
        DS_CCW  = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        PH_LOW     = 2'd0,
        PH_HIGH    = 2'd1,
        PH_HALF    = 2'd2,
        PH_INVALID = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t u;
        phase_t v;
        phase_t w;
    } phase_set_t;

    typedef struct packed {
        logic [0:0]                 motor_index;
        logic signed [FSPEED_W-1:0] ref_speed;
        logic signed [FSPEED_W-1:0] measured_speed;
        logic                       hall_u;
        logic                       hall_v;
        logic                       hall_w;
    } in_t;

    typedef struct packed {
        logic [1:0]                 drive_mode;
        logic [1:0]                 phase_u_mode;
        logic [1:0]                 phase_v_mode;
        logic [1:0]                 phase_w_mode;
        logic [DUTY_W-1:0]          duty_percent;
        logic signed [FSPEED_W-1:0] corrected_speed;
        logic                       hall_invalid;
    } out_t;

    // Serial multiplier request and status.
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Commutation inputs and results.
    typedef struct packed {
        drive_t            drive_old;
        logic              ref_zero;
        logic              ref_neg;
        logic              corr_neg;
        logic [HALL_W-1:0] hall;
    } commut_in_t;

    typedef struct packed {
        drive_t     drive;
        phase_set_t phases;
        logic       invalid;
    } commut_out_t;

    // Six-step phase modes for a hall code; backward selects the reverse table.
    function automatic phase_set_t hall_phases(input logic [HALL_W-1:0] hall,
                                               input logic backward);
        phase_set_t ph;
        ph = '{PH_INVALID, PH_INVALID, PH_INVALID};
        case (hall)
            3'd1: ph = backward ? '{PH_HALF, PH_HIGH, PH_LOW}  : '{PH_HALF, PH_LOW, PH_HIGH};
            3'd2: ph = backward ? '{PH_HIGH, PH_LOW, PH_HALF}  : '{PH_LOW, PH_HIGH, PH_HALF};
            3'd3: ph = backward ? '{PH_HIGH, PH_HALF, PH_LOW}  : '{PH_LOW, PH_HALF, PH_HIGH};
            3'd4: ph = backward ? '{PH_LOW, PH_HALF, PH_HIGH}  : '{PH_HIGH, PH_HALF, PH_LOW};
            3'd5: ph = backward ? '{PH_LOW, PH_HIGH, PH_HALF}  : '{PH_HIGH, PH_LOW, PH_HALF};
            3'd6: ph = backward ? '{PH_HALF, PH_LOW, PH_HIGH}  : '{PH_HALF, PH_HIGH, PH_LOW};
            default: ph = '{PH_INVALID, PH_INVALID, PH_INVALID};
        endcase
        return ph;
    endfunction

endpackage

[design/bldc_pi_speed_commutation_core.sv]
// ============================================================================
// bldc_pi_speed_commutation_core
// PI speed correction, drive state update, duty computation and six-step
// hall commutation for up to MOTOR_COUNT motors, one control step per input.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid, in_stall | in_data  (bpsc_pkg::in_t)
//  out     | out       | out_valid, out_stall | out_data (bpsc_pkg::out_t)
//
//  A transaction makes three passes of the 24-step bit-serial multiplier with
//  the loop enabled and one with it bypassed, plus the add and clamp stages.
//  Reset clears the integrators to zero and every drive state to stop.
//  in_stall is high from acceptance until the result is handed to the output
//  register; a stalled result holds there while the next step is accepted.
// ============================================================================
`timescale 1ns / 1ps
`include "bldc_pi_speed_commutation_core_defines.svh"

module bldc_pi_speed_commutation_core #(
    parameter int MOTOR_COUNT = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bpsc_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bpsc_pkg::out_t                      out_data
);

    localparam int GW      = bpsc_pkg::GAIN_W;
    localparam int FW      = bpsc_pkg::FRAC_W;
    localparam int SW_IN   = bpsc_pkg::FSPEED_W;
    localparam int IW      = bpsc_pkg::INTEG_W;
    localparam int MIDX_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SEL_W   = $clog2(MOTOR_COUNT + 1) + 1;
    localparam int MUL_B_W = (SW_IN + 1 > 34) ? SW_IN + 1 : 34;
    localparam int R_W     = MUL_B_W + 1 + GW - FW;
    localparam int SUM_W   = R_W + 2;
    localparam int DSUM_W  = R_W + 1;
    localparam int DHI_W   = DSUM_W - FW;

    localparam logic signed [SUM_W-1:0] SMAX =
        {{(SUM_W - SW_IN + 1){1'b0}}, {(SW_IN - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_ICLAMP,
        S_SUM,
        S_CLAMP,
        S_MAG,
        S_MUL_D,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [GW-1:0]                  prop_gain_reg;
    logic [GW-1:0]                  integ_gain_reg;
    logic [bpsc_pkg::WINDUP_W-1:0]  windup_reg;
    logic                           loop_en_reg;
    logic [GW-1:0]                  duty_gain_reg;
    logic [bpsc_pkg::OFFSET_W-1:0]  duty_off_reg;

    // Per-motor state.
    logic signed [IW-1:0]           integ_mem_reg [MOTOR_COUNT];
    bpsc_pkg::drive_t               drive_mem_reg [MOTOR_COUNT];

    // Step datapath.
    state_t                         state_reg;
    logic [MIDX_W-1:0]              motor_reg;
    logic signed [SW_IN-1:0]        ref_reg;
    logic signed [SW_IN-1:0]        meas_reg;
    logic [bpsc_pkg::HALL_W-1:0]    hall_reg;
    logic signed [IW-1:0]           integ_old_reg;
    bpsc_pkg::drive_t               drive_old_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SUM_W-1:0]        isum_reg;
    logic signed [IW-1:0]           iv_reg;
    logic signed [SUM_W-1:0]        corr_reg;
    logic [DSUM_W-1:0]              dsum_reg;
    bpsc_pkg::commut_out_t          commut_reg;
    bpsc_pkg::mul_req_t             mul_req_reg;
    logic signed [MUL_B_W-1:0]      mul_b_reg;
    logic                           out_valid_reg;
    bpsc_pkg::out_t                 out_reg;

    bpsc_pkg::mul_stat_t            mul_stat;
    logic signed [R_W-1:0]          mul_result;
    bpsc_pkg::commut_in_t           commut_in;
    bpsc_pkg::commut_out_t          commut_out;

    logic [SEL_W-1:0]               motor_ext;
    logic [SEL_W-1:0]               motor_sel;
    logic signed [MUL_B_W-1:0]      err_ext;
    logic signed [SUM_W-1:0]        ref_sum_ext;
    logic signed [SUM_W-1:0]        res_ext;
    logic signed [SUM_W-1:0]        integ_old_ext;
    logic signed [SUM_W-1:0]        iv_ext;
    logic signed [SUM_W-1:0]        w_pos;
    logic signed [SUM_W-1:0]        w_neg;
    logic signed [SUM_W-1:0]        iv_clamp;
    logic signed [SUM_W-1:0]        corr_clamp;
    logic signed [SUM_W-1:0]        mag_full;
    logic [DHI_W-1:0]               duty_hi;
    logic [bpsc_pkg::DUTY_W-1:0]    duty_sat;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= bpsc_pkg::PROP_GAIN_RST;
            integ_gain_reg <= '0;
            windup_reg     <= '0;
            loop_en_reg    <= 1'b1;
            duty_gain_reg  <= '0;
            duty_off_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpsc_pkg::REG_PROP_GAIN:    prop_gain_reg  <= cfg_data[GW-1:0];
                bpsc_pkg::REG_INTEG_GAIN:   integ_gain_reg <= cfg_data[GW-1:0];
                bpsc_pkg::REG_WINDUP_LIMIT: windup_reg     <= cfg_data[bpsc_pkg::WINDUP_W-1:0];
                bpsc_pkg::REG_LOOP_ENABLE:  loop_en_reg    <= cfg_data[0];
                bpsc_pkg::REG_DUTY_GAIN:    duty_gain_reg  <= cfg_data[GW-1:0];
                bpsc_pkg::REG_DUTY_OFFSET:  duty_off_reg   <= cfg_data[bpsc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign motor_ext = SEL_W'(in_data.motor_index);
    assign motor_sel = (motor_ext >= SEL_W'(MOTOR_COUNT)) ? SEL_W'(MOTOR_COUNT - 1) : motor_ext;

    assign err_ext = {{(MUL_B_W - SW_IN){ref_reg[SW_IN-1]}}, ref_reg}
                   - {{(MUL_B_W - SW_IN){meas_reg[SW_IN-1]}}, meas_reg};

    assign ref_sum_ext   = {{(SUM_W - SW_IN){ref_reg[SW_IN-1]}}, ref_reg};
    assign res_ext       = {{(SUM_W - R_W){mul_result[R_W-1]}}, mul_result};
    assign integ_old_ext = {{(SUM_W - IW){integ_old_reg[IW-1]}}, integ_old_reg};
    assign iv_ext        = {{(SUM_W - IW){iv_reg[IW-1]}}, iv_reg};

    assign w_pos = {{(SUM_W - bpsc_pkg::WINDUP_W){1'b0}}, windup_reg};
    assign w_neg = -w_pos;

    assign iv_clamp   = (isum_reg > w_pos) ? w_pos : ((isum_reg < w_neg) ? w_neg : isum_reg);
    assign corr_clamp = (sum_reg > SMAX) ? SMAX : ((sum_reg < SMIN) ? SMIN : sum_reg);
    assign mag_full   = corr_reg[SUM_W-1] ? -corr_reg : corr_reg;

    assign duty_hi  = dsum_reg[DSUM_W-1:FW];
    assign duty_sat = (duty_hi > DHI_W'(bpsc_pkg::DUTY_MAX)) ? bpsc_pkg::DUTY_MAX
                                                             : duty_hi[bpsc_pkg::DUTY_W-1:0];

    assign commut_in.drive_old = drive_old_reg;
    assign commut_in.ref_zero  = (ref_reg == '0);
    assign commut_in.ref_neg   = ref_reg[SW_IN-1];
    assign commut_in.corr_neg  = corr_reg[SUM_W-1];
    assign commut_in.hall      = hall_reg;

    bpsc_sermul #(
        .B_W (MUL_B_W)
    ) u_sermul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req_reg),
        .operand (mul_b_reg),
        .stat    (mul_stat),
        .result  (mul_result)
    );

    bpsc_commutate u_commutate (
        .cin  (commut_in),
        .cout (commut_out)
    );

    // ------------------------------------------------------------------
    // Per-motor state storage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                integ_mem_reg[i] <= '0;
                drive_mem_reg[i] <= bpsc_pkg::DS_STOP;
            end
        end
        else
        begin
            if (state_reg == S_ICLAMP)
                integ_mem_reg[motor_reg] <= iv_clamp[IW-1:0];
            if (state_reg == S_MAG)
                drive_mem_reg[motor_reg] <= commut_out.drive;
        end
    end

    // ------------------------------------------------------------------
    // Step sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mul_req_reg.start <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            mul_req_reg.start <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ref_reg   <= in_data.ref_speed;
                        meas_reg  <= in_data.measured_speed;
                        hall_reg  <= {in_data.hall_u, in_data.hall_v, in_data.hall_w};
                        motor_reg <= motor_sel[MIDX_W-1:0];
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    integ_old_reg <= integ_mem_reg[motor_reg];
                    drive_old_reg <= drive_mem_reg[motor_reg];
                    if (loop_en_reg)
                    begin
                        mul_req_reg.start <= 1'b1;
                        mul_req_reg.gain  <= prop_gain_reg;
                        mul_b_reg         <= err_ext;
                        state_reg         <= S_MUL_P;
                    end
                    else
                    begin
                        sum_reg   <= ref_sum_ext;
                        state_reg <= S_CLAMP;
                    end
                end
                S_MUL_P:
                begin
                    if (mul_stat.done)
                    begin
                        sum_reg           <= ref_sum_ext + res_ext;
                        mul_req_reg.start <= 1'b1;
                        mul_req_reg.gain  <= integ_gain_reg;
                        state_reg         <= S_MUL_I;
                    end
                end
                S_MUL_I:
                begin
                    if (mul_stat.done)
                    begin
                        isum_reg  <= integ_old_ext + res_ext;
                        state_reg <= S_ICLAMP;
                    end
                end
                S_ICLAMP:
                begin
                    iv_reg    <= iv_clamp[IW-1:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg   <= sum_reg + iv_ext;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    corr_reg  <= corr_clamp;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    commut_reg        <= commut_out;
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.gain  <= duty_gain_reg;
                    mul_b_reg         <= mag_full[MUL_B_W-1:0];
                    state_reg         <= S_MUL_D;
                end
                S_MUL_D:
                begin
                    if (mul_stat.done)
                    begin
                        dsum_reg  <= {1'b0, mul_result} + DSUM_W'(duty_off_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.drive_mode      <= commut_reg.drive;
                        out_reg.phase_u_mode    <= commut_reg.phases.u;
                        out_reg.phase_v_mode    <= commut_reg.phases.v;
                        out_reg.phase_w_mode    <= commut_reg.phases.w;
                        out_reg.duty_percent    <= duty_sat;
                        out_reg.corrected_speed <= corr_reg[SW_IN-1:0];
                        out_reg.hall_invalid    <= commut_reg.invalid;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BPSC_ASSERT_IMPL(a_mul_start_idle, mul_req_reg.start, !mul_stat.busy, "multiplier restarted while busy")
    `BPSC_ASSERT_NEXT(a_mul_start_busy, mul_req_reg.start, mul_stat.busy, "multiplier ignored a start")
    `BPSC_ASSERT_IMPL(a_out_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE), "result loaded outside the final step")
    `BPSC_ASSERT_IMPL(a_duty_range, out_valid_reg, out_reg.duty_percent <= bpsc_pkg::DUTY_MAX, "duty above saturation limit")

endmodule

[design/bpsc_sermul.sv]
// ============================================================================
// bpsc_sermul
// Serial-parallel multiplier: an unsigned gain, one bit per cycle LSB first,
// times a signed operand; returns the product shifted right by FRAC_W.
// ============================================================================
`timescale 1ns / 1ps

module bpsc_sermul #(
    parameter int B_W = 34,
    localparam int R_W = B_W + 1 + bpsc_pkg::GAIN_W - bpsc_pkg::FRAC_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpsc_pkg::mul_req_t   req,
    input  logic signed [B_W-1:0] operand,
    output bpsc_pkg::mul_stat_t  stat,
    output logic signed [R_W-1:0] result
);

    localparam int GW    = bpsc_pkg::GAIN_W;
    localparam int CNT_W = $clog2(GW + 1);

    logic [GW-1:0]         gain_sh_reg;
    logic signed [B_W:0]   acc_reg;
    logic [GW-1:0]         lo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic signed [B_W:0]   addend;
    logic signed [B_W:0]   sum_next;

    // The running sum never exceeds twice the operand, so B_W+1 bits hold it.
    assign addend   = gain_sh_reg[0] ? {operand[B_W-1], operand} : '0;
    assign sum_next = acc_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            gain_sh_reg <= req.gain;
            acc_reg     <= '0;
            cnt_reg     <= CNT_W'(GW);
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            gain_sh_reg <= {1'b0, gain_sh_reg[GW-1:1]};
            lo_reg      <= {sum_next[0], lo_reg[GW-1:1]};
            acc_reg     <= sum_next >>> 1;
            cnt_reg     <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = {acc_reg, lo_reg[GW-1:bpsc_pkg::FRAC_W]};

endmodule

[design/bpsc_commutate.sv]
// ============================================================================
// bpsc_commutate
// Drive state transition and six-step phase selection from the hall code.
// ============================================================================
`timescale 1ns / 1ps

module bpsc_commutate (
    input  bpsc_pkg::commut_in_t  cin,
    output bpsc_pkg::commut_out_t cout
);

    bpsc_pkg::drive_t drive_new;

    always_comb
    begin
        case (cin.drive_old)
            bpsc_pkg::DS_STOP:
                drive_new = cin.ref_neg ? bpsc_pkg::DS_CCW : bpsc_pkg::DS_CW;
            default:
            begin
                if (cin.ref_zero)
                    drive_new = bpsc_pkg::DS_STOP;
                else
                    drive_new = cin.corr_neg ? bpsc_pkg::DS_CCW : bpsc_pkg::DS_CW;
            end
        endcase
    end

    // Stop uses the forward table, like clockwise.
    assign cout.drive   = drive_new;
    assign cout.phases  = bpsc_pkg::hall_phases(cin.hall, drive_new == bpsc_pkg::DS_CCW);
    assign cout.invalid = (cin.hall == bpsc_pkg::HALL_ALL_LOW) ||
                          (cin.hall == bpsc_pkg::HALL_ALL_HIGH);

endmodule

[tb/speed_step_check_pkg.sv]
// ============================================================================
// Speed step prediction and result checking
// Predicts each control step of the PI speed and commutation core (integrator,
// drive state, duty and six-step phases per motor) and compares each result
// the core delivers, field by field, with the oldest prediction still open.
// ============================================================================
`timescale 1ns / 1ps

package speed_step_check_pkg;
    import bpsc_pkg::*;

    localparam int     MOTORS       = 2;
    localparam int     REPORT_LIMIT = 10;
    localparam longint SPEED_MAX    = (longint'(1) <<< (FSPEED_W - 1)) - 1;
    localparam longint SPEED_MIN    = -SPEED_MAX - 1;

    class speed_step_model;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [WINDUP_W-1:0] windup;
        logic                loop_on;
        logic [GAIN_W-1:0]   duty_gain;
        logic [OFFSET_W-1:0] duty_offset;
        longint              integ [MOTORS];
        drive_t              drive [MOTORS];
        out_t                expected_steps [$];
        int                  mismatch_count;

        function new();
            prop_gain      = PROP_GAIN_RST;
            integ_gain     = '0;
            windup         = '0;
            loop_on        = 1'b1;
            duty_gain      = '0;
            duty_offset    = '0;
            mismatch_count = 0;
            foreach (integ[i])
            begin
                integ[i] = 0;
                drive[i] = DS_STOP;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PROP_GAIN:    prop_gain   = data[GAIN_W-1:0];
                REG_INTEG_GAIN:   integ_gain  = data[GAIN_W-1:0];
                REG_WINDUP_LIMIT: windup      = data[WINDUP_W-1:0];
                REG_LOOP_ENABLE:  loop_on     = data[0];
                REG_DUTY_GAIN:    duty_gain   = data[GAIN_W-1:0];
                REG_DUTY_OFFSET:  duty_offset = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // Gain times value with the Q16 fraction dropped, rounding toward minus infinity.
        function longint q16_scale(longint gain, longint value);
            return (gain * value) >>> FRAC_W;
        endfunction

        function phase_set_t six_step(logic [HALL_W-1:0] hall, logic backward);
            logic [HALL_W-1:0] code;
            // The backward table is the forward table read at the complemented code.
            code = backward ? ~hall : hall;
            case (code)
                3'd1: return '{PH_HALF, PH_LOW, PH_HIGH};
                3'd2: return '{PH_LOW, PH_HIGH, PH_HALF};
                3'd3: return '{PH_LOW, PH_HALF, PH_HIGH};
                3'd4: return '{PH_HIGH, PH_HALF, PH_LOW};
                3'd5: return '{PH_HIGH, PH_LOW, PH_HALF};
                3'd6: return '{PH_HALF, PH_HIGH, PH_LOW};
                default: return '{PH_INVALID, PH_INVALID, PH_INVALID};
            endcase
        endfunction

        function void accept_step(in_t s);
            longint            ref_v, meas_v, err, acc, corr, mag, duty;
            int                m;
            drive_t            ds;
            logic [HALL_W-1:0] hall;
            phase_set_t        ph;
            out_t              e;
            m      = s.motor_index;
            ref_v  = longint'($signed(s.ref_speed));
            meas_v = longint'($signed(s.measured_speed));
            hall   = {s.hall_u, s.hall_v, s.hall_w};
            corr   = ref_v;
            if (loop_on)
            begin
                err = ref_v - meas_v;
                acc = integ[m] + q16_scale(integ_gain, err);
                if (acc > longint'(windup))
                    acc = windup;
                else if (acc < -longint'(windup))
                    acc = -longint'(windup);
                integ[m] = acc;
                corr = ref_v + q16_scale(prop_gain, err) + acc;
            end
            if (corr > SPEED_MAX)
                corr = SPEED_MAX;
            else if (corr < SPEED_MIN)
                corr = SPEED_MIN;

            ds = drive[m];
            if (ds == DS_STOP)
                ds = (ref_v < 0) ? DS_CCW : DS_CW;
            else if (ref_v == 0)
                ds = DS_STOP;
            else
                ds = (corr < 0) ? DS_CCW : DS_CW;
            drive[m] = ds;

            mag  = (corr < 0) ? -corr : corr;
            duty = (((longint'(duty_gain) * mag) >>> FRAC_W) + duty_offset) >>> FRAC_W;
            ph   = six_step(hall, ds == DS_CCW);

            e.drive_mode      = ds;
            e.phase_u_mode    = ph.u;
            e.phase_v_mode    = ph.v;
            e.phase_w_mode    = ph.w;
            e.duty_percent    = (duty > DUTY_MAX) ? DUTY_MAX : duty[DUTY_W-1:0];
            e.corrected_speed = corr[FSPEED_W-1:0];
            e.hall_invalid    = (hall == HALL_ALL_LOW) || (hall == HALL_ALL_HIGH);
            expected_steps.push_back(e);
        endfunction

        function void note_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%s", what);
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want)
                note_mismatch($sformatf("mismatch on %s: expected %0d, got %0d",
                                        name, want, got));
        endfunction

        function void check_step(out_t got);
            out_t want;
            if (expected_steps.size() == 0)
            begin
                note_mismatch($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = expected_steps.pop_front();
            check_field("drive_mode", want.drive_mode, got.drive_mode);
            check_field("phase_u_mode", want.phase_u_mode, got.phase_u_mode);
            check_field("phase_v_mode", want.phase_v_mode, got.phase_v_mode);
            check_field("phase_w_mode", want.phase_w_mode, got.phase_w_mode);
            check_field("duty_percent", want.duty_percent, got.duty_percent);
            check_field("corrected_speed", $signed(want.corrected_speed),
                        $signed(got.corrected_speed));
            check_field("hall_invalid", want.hall_invalid, got.hall_invalid);
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// ============================================================================
// Testbench for the BLDC PI speed and commutation core
// Runs directed control steps for the drive state transitions, field extremes
// and every hall code, then random steps over several register settings with
// random gaps and output stalls, and checks every result against a prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import bpsc_pkg::*;
    import speed_step_check_pkg::*;

    localparam int ONE_Q16          = 1 << FRAC_W;
    localparam int DUTY_FULL        = 100 * ONE_Q16;
    localparam int SPEED_HI         = 32'h7FFF_FFFF;
    localparam int SPEED_LO         = int'(32'h8000_0000);
    localparam int PHASES           = 10;
    localparam int STEPS_PER_PHASE  = 153;
    localparam int SETTLE_CYCLES    = 100;
    localparam int TIMEOUT_NS       = 12_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [HALL_W-1:0] HALL_SEQ [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;

    logic                  idle_on   = 1'b1;
    int                    stall_left = 0;
    int                    hall_pos [MOTORS] = '{0, 0};
    speed_step_model       model;

    bldc_pi_speed_commutation_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Result side: check each accepted transaction, then decide the next stall.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            model.check_step(out_data);
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic in_t make_step(input logic m, input int ref_v, input int meas_v,
                                      input logic [HALL_W-1:0] hall);
        in_t s;
        s.motor_index    = m;
        s.ref_speed      = ref_v;
        s.measured_speed = meas_v;
        {s.hall_u, s.hall_v, s.hall_w} = hall;
        return s;
    endfunction

    function automatic int near(input int center, input int spread);
        return center + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Mostly a motor turning through the six hall codes under a moderate speed
    // command; the rest is full-range values, zero commands and bad hall codes.
    function automatic in_t random_step();
        int                kind, m, ref_v, meas_v;
        logic [HALL_W-1:0] hall;
        kind = $urandom_range(0, 9);
        m    = $urandom_range(0, MOTORS - 1);
        if (kind == 0)
        begin
            ref_v  = $urandom;
            meas_v = $urandom;
        end
        else if (kind == 1)
        begin
            ref_v  = 0;
            meas_v = near(0, 1 << 22);
        end
        else
        begin
            ref_v  = near(0, 1 << 27);
            meas_v = near(ref_v, 1 << 22);
        end
        hall_pos[m] = (hall_pos[m] + ((ref_v < 0) ? 5 : 1)) % 6;
        hall = ($urandom_range(0, 9) == 0) ? HALL_W'($urandom_range(0, 7)) : HALL_SEQ[hall_pos[m]];
        return make_step(m, ref_v, meas_v, hall);
    endfunction

    task automatic send_item(input in_t s);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        model.accept_step(s);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (model.expected_steps.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        model.write_reg(idx, data);
    endtask

    // Registers change only with the core idle and every result collected.
    task automatic load_regs(input logic [CFG_DATA_W-1:0] kp, ki, wl, en, dg, doff);
        drain_results();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_WINDUP_LIMIT, wl);
        write_reg(REG_LOOP_ENABLE, en);
        write_reg(REG_DUTY_GAIN, dg);
        write_reg(REG_DUTY_OFFSET, doff);
        write_reg(REG_NONE, $urandom);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        model = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: both motors leave stop, one in each direction.
        send_item(make_step(0, 10 * ONE_Q16, 8 * ONE_Q16, 3'd1));
        send_item(make_step(1, -5 * ONE_Q16, 0, 3'd2));

        load_regs(ONE_Q16, ONE_Q16 / 4, 100 * ONE_Q16, 1, ONE_Q16, 10 * ONE_Q16);
        send_item(make_step(0, 0, 3 * ONE_Q16, 3'd3));
        send_item(make_step(0, 0, 0, 3'd4));
        send_item(make_step(0, 2 * ONE_Q16, 50 * ONE_Q16, 3'd5));
        send_item(make_step(1, SPEED_HI, SPEED_LO, 3'd6));
        send_item(make_step(1, SPEED_LO, SPEED_HI, 3'd0));
        send_item(make_step(0, SPEED_LO, SPEED_LO, 3'd7));
        send_item(make_step(1, SPEED_HI, SPEED_HI, 3'd1));
        for (int h = 1; h <= 6; h++)
        begin
            send_item(make_step(0, (20 + h) * ONE_Q16, 20 * ONE_Q16, HALL_W'(h)));
            send_item(make_step(1, -(20 + h) * ONE_Q16, -20 * ONE_Q16, HALL_W'(h)));
        end

        // With the loop bypassed the integrators must hold their values.
        load_regs(ONE_Q16, ONE_Q16 / 4, 100 * ONE_Q16, 0, ONE_Q16, 10 * ONE_Q16);
        send_item(make_step(0, -7 * ONE_Q16, 3 * ONE_Q16, 3'd2));
        send_item(make_step(1, 0, -ONE_Q16, 3'd5));
        send_item(make_step(0, SPEED_LO, 0, 3'd6));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_regs(0, 0, 0, 1, 0, 0);
                1: load_regs('1, '1, '1, '1, '1, '1);
                2: load_regs($urandom_range(0, 4 * ONE_Q16), $urandom_range(0, ONE_Q16),
                             $urandom, 0, $urandom_range(0, 2 * ONE_Q16), DUTY_FULL);
                default:
                    if ($urandom_range(0, 3) == 0)
                        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                    else
                        load_regs($urandom_range(0, 4 * ONE_Q16), $urandom_range(0, ONE_Q16 / 2),
                                  $urandom_range(0, 500 * ONE_Q16), $urandom_range(0, 4) != 0,
                                  $urandom_range(0, ONE_Q16), $urandom_range(0, DUTY_FULL));
            endcase
            idle_on <= (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (STEPS_PER_PHASE) send_item(random_step());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (model.mismatch_count == 0 && model.expected_steps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/bpsc_pkg.sv
design/bpsc_sermul.sv
design/bpsc_commutate.sv
design/bldc_pi_speed_commutation_core.sv
tb/speed_step_check_pkg.sv
tb/tb_top.sv
